@@ hw/rtl/qrr_pkg.sv @@
package qrr_pkg;

    localparam int COEF_W = 16;
    localparam int D_W = 34;      // b*b - 4ac, signed
    localparam int SQ_W = 32;     // floor(sqrt(D * 2^30))
    localparam int RAD_W = 64;    // radicand D * 2^30
    localparam int N_W = 36;      // -b*2^15 +/- S, signed
    localparam int NUM_W = 37;    // 2|N| + |a|
    localparam int DEN_W = 18;    // 2|a|
    localparam int ROOT_W = 32;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] ST_TWO_ROOTS = 2'd0;
    localparam logic [1:0] ST_NO_REAL = 2'd1;
    localparam logic [1:0] ST_A_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [D_W-1:0]    disc;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
    } t_item;

endpackage

@@ hw/rtl/quadratic_real_roots.sv @@
// Pipeline from input transaction to result: product registers, queue, square
// root load stage, one square root stage per root bit, numerator registers,
// one divider stage per quotient bit, output register.
// Throughput: one transaction per cycle when not stalled by back pressure;
// every stage is pipelined, one square root bit and one quotient bit per stage.
// Reset: i_rst_n synchronous active low, clears valid bits and queue pointers.
module quadratic_real_roots #(
    parameter int QUEUE_DEPTH = qrr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // coefficient stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // coef_a[15:0], coef_b[31:16], coef_c[47:32]
    // root stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // root_plus[31:0], root_minus[63:32]
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    // front: multiplies and classifies each transaction
    qrr_pkg::t_item w_push_item;
    qrr_pkg::t_item w_pop_item;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    logic [31:0]    w_root_plus;
    logic [31:0]    w_root_minus;

    qrr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_coef_a (i_s_axis_tdata[15:0]),
        .i_coef_b (i_s_axis_tdata[31:16]),
        .i_coef_c (i_s_axis_tdata[47:32]),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    // short queue decouples front from the long back pipeline
    qrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_pop_item)
    );

    // back: square root, numerators, two dividers, saturation, output register
    qrr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!w_empty),
        .i_item       (w_pop_item),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_status     (o_m_axis_tuser),
        .o_root_plus  (w_root_plus),
        .o_root_minus (w_root_minus)
    );

    assign o_m_axis_tdata = {w_root_minus, w_root_plus};

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty) else $error("queue pop while empty");

    a_roots_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != qrr_pkg::ST_TWO_ROOTS))
            |-> (o_m_axis_tdata == 64'd0)) else $error("roots set without two real roots");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == qrr_pkg::ST_TWO_ROOTS
            || o_m_axis_tuser == qrr_pkg::ST_NO_REAL
            || o_m_axis_tuser == qrr_pkg::ST_A_ZERO)) else $error("bad status code");
`endif

endmodule

@@ hw/rtl/qrr_front.sv @@
module qrr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [15:0]   i_coef_a,
    input  logic signed [15:0]   i_coef_b,
    input  logic signed [15:0]   i_coef_c,
    input  logic                 i_full,
    output logic                 o_push,
    output qrr_pkg::t_item       o_item
);

    logic                r_valid;
    logic signed [31:0]  r_bb;
    logic signed [31:0]  r_ac;
    logic signed [15:0]  r_a;
    logic signed [15:0]  r_b;
    logic signed [qrr_pkg::D_W-1:0] w_disc;

    assign o_ready = !r_valid || !i_full;
    assign o_push = r_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // products registered before the subtract
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_bb <= i_coef_b * i_coef_b;
            r_ac <= i_coef_a * i_coef_c;
            r_a <= i_coef_a;
            r_b <= i_coef_b;
        end
    end

    assign w_disc = qrr_pkg::D_W'(r_bb) - (qrr_pkg::D_W'(r_ac) <<< 2);

    always_comb begin
        o_item.disc = w_disc;
        o_item.coef_a = r_a;
        o_item.coef_b = r_b;
        if (r_a == 16'sd0) begin
            o_item.status = qrr_pkg::ST_A_ZERO;
        end else if (w_disc[qrr_pkg::D_W-1]) begin
            o_item.status = qrr_pkg::ST_NO_REAL;
        end else begin
            o_item.status = qrr_pkg::ST_TWO_ROOTS;
        end
    end

endmodule

@@ hw/rtl/qrr_queue.sv @@
module qrr_queue #(
    parameter int DEPTH = qrr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qrr_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output qrr_pkg::t_item  o_item
);

    localparam int PTR_W = $clog2(DEPTH);

    qrr_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W:0]   r_wr_ptr;
    logic [PTR_W:0]   r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full = (r_wr_ptr[PTR_W] != r_rd_ptr[PTR_W])
                 && (r_wr_ptr[PTR_W-1:0] == r_rd_ptr[PTR_W-1:0]);
    assign o_item = r_mem[r_rd_ptr[PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[PTR_W-1:0]] <= i_item;
        end
    end

endmodule

@@ hw/rtl/qrr_div.sv @@
// restoring divider, one quotient bit per stage, stalls with i_en
module qrr_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [qrr_pkg::NUM_W-1:0]     i_num,
    input  logic [qrr_pkg::DEN_W-1:0]     i_den,
    output logic [qrr_pkg::NUM_W-1:0]     o_quo
);

    localparam int NW = qrr_pkg::NUM_W;
    localparam int DW = qrr_pkg::DEN_W;

    logic [NW-1:0] r_num [NW];
    logic [DW-1:0] r_den [NW];
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_quo [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [NW-1:0] c_num;
        logic [DW-1:0] c_den;
        logic [DW-1:0] c_rem;
        logic [NW-1:0] c_quo;
        logic [DW:0]   w_sh;
        logic          w_ge;

        if (i == 0) begin : g_first
            assign c_num = i_num;
            assign c_den = i_den;
            assign c_rem = '0;
            assign c_quo = '0;
        end else begin : g_next
            assign c_num = r_num[i-1];
            assign c_den = r_den[i-1];
            assign c_rem = r_rem[i-1];
            assign c_quo = r_quo[i-1];
        end

        assign w_sh = {c_rem, c_num[NW-1]};
        assign w_ge = (w_sh >= {1'b0, c_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[i] <= c_num << 1;
                r_den[i] <= c_den;
                r_rem[i] <= w_ge ? DW'(w_sh - {1'b0, c_den}) : w_sh[DW-1:0];
                r_quo[i] <= {c_quo[NW-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule

@@ hw/rtl/qrr_back.sv @@
module qrr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  qrr_pkg::t_item       i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [31:0]          o_root_plus,
    output logic [31:0]          o_root_minus
);

    localparam int SQ = qrr_pkg::SQ_W;
    localparam int RW = qrr_pkg::RAD_W;
    localparam int NW = qrr_pkg::NUM_W;

    logic w_en;

    // square root stages; index 0 is the load stage
    logic        r_sq_v    [SQ+1];
    logic [1:0]  r_sq_st   [SQ+1];
    logic signed [15:0] r_sq_a [SQ+1];
    logic signed [15:0] r_sq_b [SQ+1];
    logic [RW-1:0] r_sq_rem  [SQ+1];
    logic [SQ-1:0] r_sq_root [SQ+1];

    logic                r_p1_v;
    logic [1:0]          r_p1_st;
    logic signed [15:0]  r_p1_a;
    logic signed [qrr_pkg::N_W-1:0] r_p1_np;
    logic signed [qrr_pkg::N_W-1:0] r_p1_nm;

    logic                r_p2_v;
    logic [1:0]          r_p2_st;
    logic [NW-1:0]       r_p2_num_p;
    logic [NW-1:0]       r_p2_num_m;
    logic [qrr_pkg::DEN_W-1:0] r_p2_den;
    logic                r_p2_neg_p;
    logic                r_p2_neg_m;

    logic        r_dv_v     [NW];
    logic [1:0]  r_dv_st    [NW];
    logic        r_dv_neg_p [NW];
    logic        r_dv_neg_m [NW];
    logic [NW-1:0] w_quo_p;
    logic [NW-1:0] w_quo_m;

    logic        r_out_v;
    logic [1:0]  r_out_st;
    logic [31:0] r_out_p;
    logic [31:0] r_out_m;

    assign w_en = !r_out_v || i_ready;
    assign o_pop = w_en && i_item_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_v[0] <= i_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_st[0] <= i_item.status;
            r_sq_a[0] <= i_item.coef_a;
            r_sq_b[0] <= i_item.coef_b;
            r_sq_root[0] <= '0;
            if (i_item.status == qrr_pkg::ST_TWO_ROOTS) begin
                r_sq_rem[0] <= {i_item.disc, 30'b0};
            end else begin
                r_sq_rem[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam int BIT = SQ - 1 - k;
        logic [RW-1:0] w_trial;
        logic          w_ge;

        assign w_trial = (RW'(r_sq_root[k]) << (BIT + 1)) | (RW'(1) << (2 * BIT));
        assign w_ge = (r_sq_rem[k] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_st[k+1] <= r_sq_st[k];
                r_sq_a[k+1] <= r_sq_a[k];
                r_sq_b[k+1] <= r_sq_b[k];
                r_sq_rem[k+1] <= w_ge ? r_sq_rem[k] - w_trial : r_sq_rem[k];
                r_sq_root[k+1] <= r_sq_root[k] | (w_ge ? (SQ'(1) << BIT) : '0);
            end
        end
    end

    // numerators -b*2^15 +/- S
    logic signed [qrr_pkg::N_W-1:0] w_nb;
    assign w_nb = -(qrr_pkg::N_W'(r_sq_b[SQ]) <<< 15);

    // magnitudes for the rounded divide: (2|N| + |a|) / (2|a|)
    logic [qrr_pkg::N_W-1:0] w_mag_p;
    logic [qrr_pkg::N_W-1:0] w_mag_m;
    logic [16:0]             w_den;
    assign w_mag_p = r_p1_np[qrr_pkg::N_W-1] ? qrr_pkg::N_W'(-r_p1_np) : r_p1_np;
    assign w_mag_m = r_p1_nm[qrr_pkg::N_W-1] ? qrr_pkg::N_W'(-r_p1_nm) : r_p1_nm;
    assign w_den = r_p1_a[15] ? 17'(-17'(r_p1_a)) : 17'(r_p1_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= r_sq_v[SQ];
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_st <= r_sq_st[SQ];
            r_p1_a <= r_sq_a[SQ];
            r_p1_np <= w_nb + qrr_pkg::N_W'(r_sq_root[SQ]);
            r_p1_nm <= w_nb - qrr_pkg::N_W'(r_sq_root[SQ]);
            r_p2_st <= r_p1_st;
            r_p2_num_p <= {w_mag_p, 1'b0} + NW'(w_den);
            r_p2_num_m <= {w_mag_m, 1'b0} + NW'(w_den);
            r_p2_den <= {w_den, 1'b0};
            r_p2_neg_p <= r_p1_np[qrr_pkg::N_W-1] ^ r_p1_a[15];
            r_p2_neg_m <= r_p1_nm[qrr_pkg::N_W-1] ^ r_p1_a[15];
        end
    end

    qrr_div u_div_plus (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_p2_num_p),
        .i_den (r_p2_den),
        .o_quo (w_quo_p)
    );

    qrr_div u_div_minus (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_p2_num_m),
        .i_den (r_p2_den),
        .o_quo (w_quo_m)
    );

    // side band that rides along with the divider stages
    for (genvar j = 0; j < NW; j++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[j] <= (j == 0) ? r_p2_v : r_dv_v[(j == 0) ? 0 : j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (j == 0) begin
                    r_dv_st[j] <= r_p2_st;
                    r_dv_neg_p[j] <= r_p2_neg_p;
                    r_dv_neg_m[j] <= r_p2_neg_m;
                end else begin
                    r_dv_st[j] <= r_dv_st[(j == 0) ? 0 : j-1];
                    r_dv_neg_p[j] <= r_dv_neg_p[(j == 0) ? 0 : j-1];
                    r_dv_neg_m[j] <= r_dv_neg_m[(j == 0) ? 0 : j-1];
                end
            end
        end
    end

    function automatic logic [31:0] sat_root(input logic [NW-1:0] q, input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = (q > NW'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'(~q + 1'b1);
        end else begin
            r = (q > NW'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_dv_v[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_st <= r_dv_st[NW-1];
            if (r_dv_st[NW-1] == qrr_pkg::ST_TWO_ROOTS) begin
                r_out_p <= sat_root(w_quo_p, r_dv_neg_p[NW-1]);
                r_out_m <= sat_root(w_quo_m, r_dv_neg_m[NW-1]);
            end else begin
                r_out_p <= '0;
                r_out_m <= '0;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_status = r_out_st;
    assign o_root_plus = r_out_p;
    assign o_root_minus = r_out_m;

endmodule
